### rtl/core/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg: shared definitions for the complex fixed-point ALU
// Command and status codes, datapath widths, and the records that travel
// down the divider pipeline.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int DataW    = 16;
	localparam int FracBits = 8;
	localparam int CmdW     = 4;
	localparam int StatW    = 2;
	localparam int ProdW    = 2 * DataW;          // one signed product
	localparam int MagW     = ProdW + 1;          // magnitude of a sum of two products
	localparam int DenW     = ProdW;              // squared magnitude of b
	localparam int NumW     = MagW + FracBits;    // scaled numerator
	localparam int QW       = DataW;              // quotient bits produced
	localparam int CmpW     = DenW + QW + 1;      // width of the divider compares
	localparam int DivDepth = QW;                 // one quotient bit per stage

	localparam logic [CmdW-1:0] CmdAdd = 4'd0;
	localparam logic [CmdW-1:0] CmdSub = 4'd1;
	localparam logic [CmdW-1:0] CmdMul = 4'd2;
	localparam logic [CmdW-1:0] CmdDiv = 4'd3;
	localparam logic [CmdW-1:0] CmdNeg = 4'd4;
	localparam logic [CmdW-1:0] CmdEq  = 4'd5;
	localparam logic [CmdW-1:0] CmdNe  = 4'd6;
	localparam logic [CmdW-1:0] CmdLt  = 4'd7;
	localparam logic [CmdW-1:0] CmdLe  = 4'd8;
	localparam logic [CmdW-1:0] CmdGt  = 4'd9;
	localparam logic [CmdW-1:0] CmdGe  = 4'd10;

	localparam logic [StatW-1:0] StatOk  = 2'd0;
	localparam logic [StatW-1:0] StatDz  = 2'd1;
	localparam logic [StatW-1:0] StatSat = 2'd2;

	// Per-item record carried alongside the divider. For a divide the
	// magnitudes are the numerators; otherwise they are the final magnitudes.
	typedef struct packed {
		logic            is_div;
		logic            dz;
		logic            cmp;
		logic            re_neg;
		logic            im_neg;
		logic [MagW-1:0] re_mag;
		logic [MagW-1:0] im_mag;
	} side_t;

	typedef struct packed {
		logic [DenW-1:0] den;
		logic [NumW-1:0] rem_re;
		logic [NumW-1:0] rem_im;
		logic [QW-1:0]   q_re;
		logic [QW-1:0]   q_im;
		logic            ov_re;
		logic            ov_im;
		side_t           side;
	} dstage_t;

	typedef struct packed {
		logic             sat;
		logic [DataW-1:0] val;
	} clamp_t;

	// Clamp a sign-magnitude value into the signed data range.
	function automatic clamp_t clamp_sm(input logic neg, input logic [MagW:0] mag);
		clamp_t r;
		logic [MagW:0] lim;
		lim = {{(MagW+1-DataW){1'b0}}, 1'b1, {(DataW-1){1'b0}}};
		r.sat = 1'b0;
		if (neg) begin
			if (mag > lim) begin
				r.sat = 1'b1;
				r.val = {1'b1, {(DataW-1){1'b0}}};
			end else begin
				r.val = DataW'(~mag + 1'b1);
			end
		end else begin
			if (mag > lim - 1'b1) begin
				r.sat = 1'b1;
				r.val = {1'b0, {(DataW-1){1'b1}}};
			end else begin
				r.val = mag[DataW-1:0];
			end
		end
		return r;
	endfunction

endpackage

### rtl/core/complex_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// complex_fixed_point_alu: pipelined complex fixed-point arithmetic unit
// Add, subtract, multiply, divide, negate and six comparisons on signed
// Q8.8 complex operands, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
// Usage:
// The caller presents command, a_re, a_im, b_re and b_im and raises start.
// An item is accepted at every rising edge where start is high and busy is
// low. The pipeline never stalls, so busy is always low and an item may be
// issued on every clock cycle.
// Each item produces exactly one result, which stands on the ports after
// passing through every stage listed below, in issue order. The result
// (result_re, result_im, compare_true, status) stands there for one cycle,
// marked by done. The receiver cannot hold results off, and none is needed:
// the block never waits on it.
// The depth is set by the divider, which resolves one quotient bit per
// stage over 16 stages; all commands take the same path so order holds.
// An asynchronous low on arst_n clears all valid bits, so no result appears
// until new items are issued; payload registers are not cleared.
// Stages: input register, products and squares, sum and select (into the
// divider entry stage), 16 divider stages, clamp and output register.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [cfa_pkg::CmdW-1:0]         command,
	input  logic signed [cfa_pkg::DataW-1:0] a_re,
	input  logic signed [cfa_pkg::DataW-1:0] a_im,
	input  logic signed [cfa_pkg::DataW-1:0] b_re,
	input  logic signed [cfa_pkg::DataW-1:0] b_im,
	output logic                             done,
	output logic signed [cfa_pkg::DataW-1:0] result_re,
	output logic signed [cfa_pkg::DataW-1:0] result_im,
	output logic                             compare_true,
	output logic [cfa_pkg::StatW-1:0]        status
);

	localparam int SumW = cfa_pkg::MagW + 1;

	// Stage 1: registered operands.
	logic                             v_s1;
	logic [cfa_pkg::CmdW-1:0]         cmd_s1;
	logic signed [cfa_pkg::DataW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// Stage 2: products and squares.
	logic                             v_s2;
	logic [cfa_pkg::CmdW-1:0]         cmd_s2;
	logic signed [cfa_pkg::DataW-1:0] ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [cfa_pkg::ProdW-1:0] rr_s2, ii_s2, ri_s2, ir_s2;
	logic signed [cfa_pkg::ProdW-1:0] sar_s2, sai_s2, sbr_s2, sbi_s2;

	// Sum and select, feeding the divider.
	cfa_pkg::side_t             side;
	logic [cfa_pkg::DenW-1:0]   mb_den;
	logic signed [SumW-1:0]     vre, vim;
	logic [SumW-1:0]            ma, mb;
	logic [cfa_pkg::MagW-1:0]   mre, mim;

	logic                       dv;
	cfa_pkg::dstage_t           dstg;

	// Final clamp.
	logic [cfa_pkg::MagW:0]     fre, fim;
	cfa_pkg::clamp_t            cre, cim;

	// No stage ever waits, so the block is always ready.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= command;
		ar_s1  <= a_re;
		ai_s1  <= a_im;
		br_s1  <= b_re;
		bi_s1  <= b_im;

		cmd_s2 <= cmd_s1;
		ar_s2  <= ar_s1;
		ai_s2  <= ai_s1;
		br_s2  <= br_s1;
		bi_s2  <= bi_s1;
		rr_s2  <= ar_s1 * br_s1;
		ii_s2  <= ai_s1 * bi_s1;
		ri_s2  <= ar_s1 * bi_s1;
		ir_s2  <= ai_s1 * br_s1;
		sar_s2 <= ar_s1 * ar_s1;
		sai_s2 <= ai_s1 * ai_s1;
		sbr_s2 <= br_s1 * br_s1;
		sbi_s2 <= bi_s1 * bi_s1;
	end

	// Squared magnitudes are nonnegative, so the products are taken unsigned.
	assign ma = SumW'($unsigned(sar_s2)) + SumW'($unsigned(sai_s2));
	assign mb = SumW'($unsigned(sbr_s2)) + SumW'($unsigned(sbi_s2));
	assign mb_den = mb[cfa_pkg::DenW-1:0];

	// Signed value of each lane before magnitude and clamping.
	always_comb begin
		vre = '0;
		vim = '0;
		case (cmd_s2)
			cfa_pkg::CmdAdd: begin
				vre = SumW'(ar_s2) + SumW'(br_s2);
				vim = SumW'(ai_s2) + SumW'(bi_s2);
			end
			cfa_pkg::CmdSub: begin
				vre = SumW'(ar_s2) - SumW'(br_s2);
				vim = SumW'(ai_s2) - SumW'(bi_s2);
			end
			cfa_pkg::CmdMul: begin
				vre = SumW'(rr_s2) - SumW'(ii_s2);
				vim = SumW'(ri_s2) + SumW'(ir_s2);
			end
			cfa_pkg::CmdDiv: begin
				vre = SumW'(rr_s2) + SumW'(ii_s2);
				vim = SumW'(ir_s2) - SumW'(ri_s2);
			end
			cfa_pkg::CmdNeg: begin
				vre = -SumW'(ar_s2);
				vim = -SumW'(ai_s2);
			end
			default: begin
			end
		endcase
	end

	assign mre = vre[SumW-1] ? cfa_pkg::MagW'(-vre) : vre[cfa_pkg::MagW-1:0];
	assign mim = vim[SumW-1] ? cfa_pkg::MagW'(-vim) : vim[cfa_pkg::MagW-1:0];

	always_comb begin
		side.is_div = (cmd_s2 == cfa_pkg::CmdDiv);
		side.dz     = (cmd_s2 == cfa_pkg::CmdDiv) && (mb == '0);
		side.re_neg = vre[SumW-1];
		side.im_neg = vim[SumW-1];
		side.re_mag = mre;
		side.im_mag = mim;
		// Multiply drops the fraction bits of the exact product sum.
		if (cmd_s2 == cfa_pkg::CmdMul) begin
			side.re_mag = mre >> cfa_pkg::FracBits;
			side.im_mag = mim >> cfa_pkg::FracBits;
		end
		case (cmd_s2)
			cfa_pkg::CmdEq: side.cmp = (ar_s2 == br_s2) && (ai_s2 == bi_s2);
			cfa_pkg::CmdNe: side.cmp = !((ar_s2 == br_s2) && (ai_s2 == bi_s2));
			cfa_pkg::CmdLt: side.cmp = ma < mb;
			cfa_pkg::CmdLe: side.cmp = ma <= mb;
			cfa_pkg::CmdGt: side.cmp = ma > mb;
			cfa_pkg::CmdGe: side.cmp = ma >= mb;
			default:        side.cmp = 1'b0;
		endcase
	end

	cfa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (v_s2),
		.den     (mb_den),
		.side_in (side),
		.out_vld (dv),
		.out_stg (dstg)
	);

	// A divide quotient that overflowed the quotient width is forced past
	// the limit so that the clamp saturates it.
	always_comb begin
		fre = {1'b0, dstg.side.re_mag};
		fim = {1'b0, dstg.side.im_mag};
		if (dstg.side.is_div) begin
			fre = dstg.ov_re ? (cfa_pkg::MagW+1)'(1) << cfa_pkg::QW
			                 : (cfa_pkg::MagW+1)'(dstg.q_re);
			fim = dstg.ov_im ? (cfa_pkg::MagW+1)'(1) << cfa_pkg::QW
			                 : (cfa_pkg::MagW+1)'(dstg.q_im);
		end
	end

	assign cre = cfa_pkg::clamp_sm(dstg.side.re_neg, fre);
	assign cim = cfa_pkg::clamp_sm(dstg.side.im_neg, fim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv;
		end
	end

	always_ff @(posedge clk) begin
		compare_true <= dstg.side.cmp;
		if (dstg.side.dz) begin
			result_re <= '0;
			result_im <= '0;
			status    <= cfa_pkg::StatDz;
		end else begin
			result_re <= cre.val;
			result_im <= cim.val;
			status    <= (cre.sat | cim.sat) ? cfa_pkg::StatSat : cfa_pkg::StatOk;
		end
	end

endmodule

### rtl/core/cfa_div.sv
// ----------------------------------------------------------------------------
// cfa_div: pipelined restoring divider, two lanes sharing one divisor
// Computes num * 2^FracBits / den for the real and imaginary lanes, one
// quotient bit per stage, and flags quotients too large for the quotient width.
// ----------------------------------------------------------------------------
module cfa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [cfa_pkg::DenW-1:0] den,
	input  cfa_pkg::side_t      side_in,
	output logic                out_vld,
	output cfa_pkg::dstage_t    out_stg
);

	cfa_pkg::dstage_t                stg_s [0:cfa_pkg::DivDepth];
	logic [cfa_pkg::DivDepth:0]      vld_s;
	logic [cfa_pkg::NumW-1:0]        num_re, num_im;
	logic [cfa_pkg::CmpW-1:0]        den_top;

	function automatic logic [cfa_pkg::CmpW-1:0] CmpW_ext(input logic [cfa_pkg::NumW-1:0] v);
		return {{(cfa_pkg::CmpW-cfa_pkg::NumW){1'b0}}, v};
	endfunction

	assign num_re  = {side_in.re_mag, {cfa_pkg::FracBits{1'b0}}};
	assign num_im  = {side_in.im_mag, {cfa_pkg::FracBits{1'b0}}};
	assign den_top = {{(cfa_pkg::CmpW-cfa_pkg::DenW){1'b0}}, den} << cfa_pkg::QW;

	// Entry stage: scale numerators and detect quotients of 2^QW or more.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		stg_s[0].den    <= den;
		stg_s[0].rem_re <= num_re;
		stg_s[0].rem_im <= num_im;
		stg_s[0].q_re   <= '0;
		stg_s[0].q_im   <= '0;
		stg_s[0].ov_re  <= CmpW_ext(num_re) >= den_top;
		stg_s[0].ov_im  <= CmpW_ext(num_im) >= den_top;
		stg_s[0].side   <= side_in;
	end

	for (genvar k = 0; k < cfa_pkg::DivDepth; k++) begin : g_stage
		localparam int Bit = cfa_pkg::QW - 1 - k;
		logic [cfa_pkg::CmpW-1:0] dsh;
		logic                     ge_re, ge_im;
		logic [cfa_pkg::CmpW-1:0] dif_re, dif_im;
		cfa_pkg::dstage_t         nxt;

		assign dsh    = {{(cfa_pkg::CmpW-cfa_pkg::DenW){1'b0}}, stg_s[k].den} << Bit;
		assign ge_re  = CmpW_ext(stg_s[k].rem_re) >= dsh;
		assign ge_im  = CmpW_ext(stg_s[k].rem_im) >= dsh;
		assign dif_re = CmpW_ext(stg_s[k].rem_re) - dsh;
		assign dif_im = CmpW_ext(stg_s[k].rem_im) - dsh;

		always_comb begin
			nxt        = stg_s[k];
			nxt.rem_re = ge_re ? dif_re[cfa_pkg::NumW-1:0] : stg_s[k].rem_re;
			nxt.rem_im = ge_im ? dif_im[cfa_pkg::NumW-1:0] : stg_s[k].rem_im;
			nxt.q_re   = stg_s[k].q_re | (cfa_pkg::QW'(ge_re) << Bit);
			nxt.q_im   = stg_s[k].q_im | (cfa_pkg::QW'(ge_im) << Bit);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			stg_s[k+1] <= nxt;
		end
	end

	assign out_vld = vld_s[cfa_pkg::DivDepth];
	assign out_stg = stg_s[cfa_pkg::DivDepth];

endmodule
